>>> rtl/mmlp_pkg.sv
// shared types, constants and tables of the music macro language parser
`timescale 1ns / 1ps

package mmlp_pkg;

  // field widths
  localparam int unsigned ByteW     = 8;
  localparam int unsigned AccW      = 16;
  localparam int unsigned OctW      = 3;
  localparam int unsigned NoteW     = 7;
  localparam int unsigned LenW      = 7;
  localparam int unsigned DotW      = 4;
  localparam int unsigned TempoW    = 8;
  localparam int unsigned ArticW    = 2;
  localparam int unsigned WaveW     = 3;
  localparam int unsigned SampleW   = 8;
  localparam int unsigned SampleCntW = 9;

  // clamps
  localparam int unsigned OctaveMax   = 6;
  localparam int unsigned LenMax      = 64;
  localparam int unsigned TempoMin    = 32;
  localparam int unsigned TempoMax    = 255;
  localparam int unsigned NoteMax     = 84;
  localparam int unsigned DotMax      = 15;
  localparam int unsigned SampleLimit = 256;
  localparam int unsigned AccMax      = 65535;

  // waveform codes
  localparam logic [WaveW-1:0] WaveSquare   = 3'd0;
  localparam logic [WaveW-1:0] WaveSine     = 3'd1;
  localparam logic [WaveW-1:0] WaveSawtooth = 3'd2;
  localparam logic [WaveW-1:0] WaveRampDown = 3'd3;
  localparam logic [WaveW-1:0] WaveTriangle = 3'd4;
  localparam logic [WaveW-1:0] WaveSample   = 3'd5;

  // articulation codes
  localparam logic [ArticW-1:0] ArticLegato   = 2'd0;
  localparam logic [ArticW-1:0] ArticNormal   = 2'd1;
  localparam logic [ArticW-1:0] ArticStaccato = 2'd2;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_COMMENT = 4'd1,
    MODE_ONUM    = 4'd2,
    MODE_LNUM    = 4'd3,
    MODE_TNUM    = 4'd4,
    MODE_NNUM    = 4'd5,
    MODE_PNUM    = 4'd6,
    MODE_WNUM    = 4'd7,
    MODE_NACC    = 4'd8,
    MODE_NLEN    = 4'd9,
    MODE_NDIG    = 4'd10,
    MODE_DOTS    = 4'd11,
    MODE_MSEL    = 4'd12,
    MODE_WSEL    = 4'd13
  } mode_e;

  typedef struct packed {
    mode_e               mode;
    logic [AccW-1:0]     acc;
    logic [OctW-1:0]     octave;
    logic [LenW-1:0]     dlen;
    logic [TempoW-1:0]   tempo;
    logic [ArticW-1:0]   artic;
    logic [WaveW-1:0]    wave;
    logic                full;
    logic [SampleW-1:0]  ssel;
    logic [NoteW-1:0]    pnote;
    logic                pkind;
    logic [LenW-1:0]     pden;
    logic [DotW-1:0]     pdots;
  } parse_state_t;

  typedef struct packed {
    logic                kind;
    logic [NoteW-1:0]    note;
    logic [LenW-1:0]     den;
    logic [DotW-1:0]     dots;
    logic [TempoW-1:0]   tempo;
    logic [ArticW-1:0]   artic;
    logic [WaveW-1:0]    wave;
    logic                full;
    logic [SampleW-1:0]  ssel;
    logic                endm;
  } event_t;

  localparam parse_state_t StateReset = '{
    mode:   MODE_IDLE,
    acc:    '0,
    octave: 3'd4,
    dlen:   7'd4,
    tempo:  8'd120,
    artic:  ArticNormal,
    wave:   WaveSquare,
    full:   1'b0,
    ssel:   '0,
    pnote:  '0,
    pkind:  1'b0,
    pden:   '0,
    pdots:  '0
  };

  // semitone offset of note letters a..g within an octave
  function automatic logic [3:0] semitone(input logic [2:0] idx);
    logic [3:0] s;
    case (idx)
      3'd0:    s = 4'd9;
      3'd1:    s = 4'd11;
      3'd2:    s = 4'd0;
      3'd3:    s = 4'd2;
      3'd4:    s = 4'd4;
      3'd5:    s = 4'd5;
      3'd6:    s = 4'd7;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

>>> rtl/mmlp_text_if.sv
// text byte channel: valid/ready handshake carrying one character
`timescale 1ns / 1ps

interface mmlp_text_if import mmlp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] text_byte;
  logic             end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

>>> rtl/mmlp_event_if.sv
// note event channel: valid/ready handshake carrying one note or rest event
`timescale 1ns / 1ps

interface mmlp_event_if import mmlp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               event_kind;
  logic [NoteW-1:0]   note_number;
  logic [LenW-1:0]    length_denominator;
  logic [DotW-1:0]    dot_count;
  logic [TempoW-1:0]  tempo_value;
  logic [ArticW-1:0]  articulation;
  logic [WaveW-1:0]   waveform_kind;
  logic               full_sample_flag;
  logic [SampleW-1:0] sample_index;
  logic               end_marker;

  modport source (
    output valid, output event_kind, output note_number, output length_denominator,
    output dot_count, output tempo_value, output articulation, output waveform_kind,
    output full_sample_flag, output sample_index, output end_marker, input ready
  );
  modport sink (
    input valid, input event_kind, input note_number, input length_denominator,
    input dot_count, input tempo_value, input articulation, input waveform_kind,
    input full_sample_flag, input sample_index, input end_marker, output ready
  );
endinterface

>>> rtl/music_macro_language_parser.sv
// top level of the music macro language parser: parse state, result register, handshakes
`timescale 1ns / 1ps
// an event is registered in the result register when the text byte that closes it is accepted
// throughput: one byte per cycle unless an event stalls; state register updates in one pass
// a byte is taken while a finished event waits, as long as that event leaves in the same cycle
// reset: rst_ni asynchronous active low; octave 4, length 4, tempo 120, normal articulation,
// square wave, sample count 0, parser idle and no event pending

module music_macro_language_parser import mmlp_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [SampleCntW-1:0] cfg_wdata_i,
  mmlp_text_if.sink             text_i,
  mmlp_event_if.source          event_o
);

  parse_state_t          state_q, state_d;
  logic [SampleCntW-1:0] sample_count_q;
  event_t                event_q, step_event;
  logic                  out_valid_q;
  logic                  step_emit;
  logic                  in_accept;

  // byte can be taken when the result register is empty or drains this cycle
  assign text_i.ready = !out_valid_q || event_o.ready;
  assign in_accept    = text_i.valid && text_i.ready;

  mmlp_step u_step (
    .state_i        (state_q),
    .text_byte_i    (text_i.text_byte),
    .end_of_text_i  (text_i.end_of_text),
    .sample_count_i (sample_count_q),
    .state_o        (state_d),
    .emit_o         (step_emit),
    .event_o        (step_event)
  );

  // parse state advances once per accepted transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (in_accept) begin
      state_q <= state_d;
    end
  end

  // sample count register, values past the limit act as the limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= '0;
    end else if (cfg_we_i) begin
      sample_count_q <= (cfg_wdata_i > SampleCntW'(SampleLimit)) ?
                        SampleCntW'(SampleLimit) : cfg_wdata_i;
    end
  end

  // result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept && step_emit) begin
      out_valid_q <= 1'b1;
    end else if (event_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept && step_emit) begin
      event_q <= step_event;
    end
  end

  assign event_o.valid              = out_valid_q;
  assign event_o.event_kind         = event_q.kind;
  assign event_o.note_number        = event_q.note;
  assign event_o.length_denominator = event_q.den;
  assign event_o.dot_count          = event_q.dots;
  assign event_o.tempo_value        = event_q.tempo;
  assign event_o.articulation       = event_q.artic;
  assign event_o.waveform_kind      = event_q.wave;
  assign event_o.full_sample_flag   = event_q.full;
  assign event_o.sample_index       = event_q.ssel;
  assign event_o.end_marker         = event_q.endm;

`ifndef SYNTHESIS
  // a waiting event that is not taken blocks the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !event_o.ready) |-> !text_i.ready)
    else $error("byte accepted while result register is stalled");

  // end of text always leaves the parser idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && text_i.end_of_text) |=> (state_q.mode == MODE_IDLE))
    else $error("parser not idle after end of text");

  // settings stay inside their clamps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.octave <= OctW'(OctaveMax)) && (state_q.tempo >= TempoW'(TempoMin)) &&
    (state_q.dlen <= LenW'(LenMax)))
    else $error("octave, tempo or default length out of range");

  // a flush event only comes from an end of text transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && step_emit && step_event.endm) |-> text_i.end_of_text)
    else $error("end marker without end of text");

  // an event reaches the result register only from an accepted transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_accept && step_emit))
    else $error("result became valid without a closing byte");
`endif

endmodule

>>> rtl/mmlp_step.sv
// next-state and event logic of the parser for one text byte
`timescale 1ns / 1ps

module mmlp_step import mmlp_pkg::*; (
  input  parse_state_t          state_i,
  input  logic [ByteW-1:0]      text_byte_i,
  input  logic                  end_of_text_i,
  input  logic [SampleCntW-1:0] sample_count_i,
  output parse_state_t          state_o,
  output logic                  emit_o,
  output event_t                event_o
);

  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChCr    = 8'h0d;
  localparam logic [ByteW-1:0] ChLf    = 8'h0a;
  localparam logic [ByteW-1:0] ChQuote = 8'h27;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;
  localparam logic [ByteW-1:0] ChDot   = 8'h2e;
  localparam logic [ByteW-1:0] ChMinus = 8'h2d;
  localparam logic [ByteW-1:0] ChPlus  = 8'h2b;
  localparam logic [ByteW-1:0] ChHash  = 8'h23;
  localparam logic [ByteW-1:0] ChLess  = 8'h3c;
  localparam logic [ByteW-1:0] ChMore  = 8'h3e;
  localparam logic [ByteW-1:0] ChUpA   = 8'h41;
  localparam logic [ByteW-1:0] ChUpZ   = 8'h5a;
  localparam logic [ByteW-1:0] ChA     = 8'h61;
  localparam logic [ByteW-1:0] ChG     = 8'h67;
  localparam logic [ByteW-1:0] ChF     = 8'h66;
  localparam logic [ByteW-1:0] ChL     = 8'h6c;
  localparam logic [ByteW-1:0] ChM     = 8'h6d;
  localparam logic [ByteW-1:0] ChN     = 8'h6e;
  localparam logic [ByteW-1:0] ChO     = 8'h6f;
  localparam logic [ByteW-1:0] ChP     = 8'h70;
  localparam logic [ByteW-1:0] ChQ     = 8'h71;
  localparam logic [ByteW-1:0] ChR     = 8'h72;
  localparam logic [ByteW-1:0] ChS     = 8'h73;
  localparam logic [ByteW-1:0] ChT     = 8'h74;
  localparam logic [ByteW-1:0] ChW     = 8'h77;

  localparam int unsigned ProdW = AccW + 4;

  function automatic logic [LenW-1:0] clamp_len(input logic [AccW-1:0] v);
    return (v > AccW'(LenMax)) ? LenW'(LenMax) : v[LenW-1:0];
  endfunction

  function automatic logic [DotW-1:0] add_dot(input logic [DotW-1:0] d);
    return (d < DotW'(DotMax)) ? d + DotW'(1) : d;
  endfunction

  // apply a gathered number
  function automatic parse_state_t settle(input parse_state_t st,
                                          input logic [SampleCntW-1:0] scount);
    parse_state_t    r;
    logic [AccW-1:0] v;
    r = st;
    v = st.acc;
    r.mode = MODE_IDLE;
    case (st.mode)
      MODE_ONUM: begin
        r.octave = (v > AccW'(OctaveMax)) ? OctW'(OctaveMax) : v[OctW-1:0];
      end
      MODE_LNUM: begin
        if (v == '0) begin
          r.dlen = (st.wave == WaveSample) ? '0 : LenW'(1);
        end else begin
          r.dlen = clamp_len(v);
        end
      end
      MODE_TNUM: begin
        if (v < AccW'(TempoMin)) begin
          r.tempo = TempoW'(TempoMin);
        end else if (v > AccW'(TempoMax)) begin
          r.tempo = TempoW'(TempoMax);
        end else begin
          r.tempo = v[TempoW-1:0];
        end
      end
      MODE_WNUM: begin
        if (v < AccW'(scount)) begin
          r.ssel = v[SampleW-1:0];
          r.wave = WaveSample;
        end
      end
      MODE_NNUM: begin
        r.pkind = 1'b0;
        r.pnote = (v > AccW'(NoteMax)) ? NoteW'(NoteMax) : v[NoteW-1:0];
        r.pden  = st.dlen;
        r.mode  = MODE_DOTS;
      end
      MODE_PNUM: begin
        r.pkind = 1'b1;
        r.pnote = '0;
        r.pden  = (v == '0) ? LenW'(1) : clamp_len(v);
        r.mode  = MODE_DOTS;
      end
      MODE_NDIG: begin
        r.pden = (st.dlen != '0 && v == '0) ? st.dlen : clamp_len(v);
        r.mode = MODE_DOTS;
      end
      default: ;
    endcase
    return r;
  endfunction

  // interpret a byte as the start of a command
  function automatic parse_state_t do_command(input parse_state_t st,
                                              input logic [ByteW-1:0] c,
                                              input logic [ByteW-1:0] lc);
    parse_state_t r;
    r = st;
    r.mode = MODE_IDLE;
    if (c == ChSpace || (c >= ChTab && c <= ChCr)) begin
      r.mode = MODE_IDLE;
    end else if (c == ChQuote) begin
      r.mode = MODE_COMMENT;
    end else if (lc >= ChA && lc <= ChG) begin
      // twelve semitones per octave, plus one so that note 0 means silence
      r.pnote = NoteW'({1'b0, st.octave, 3'b000}) + NoteW'({2'b00, st.octave, 2'b00})
              + NoteW'(semitone(lc[2:0] - 3'd1)) + NoteW'(1);
      r.pkind = 1'b0;
      r.pden  = st.dlen;
      r.pdots = '0;
      r.mode  = MODE_NACC;
    end else begin
      r.acc = '0;
      case (lc)
        ChO: r.mode = MODE_ONUM;
        ChL: r.mode = MODE_LNUM;
        ChT: r.mode = MODE_TNUM;
        ChN: begin
          r.pdots = '0;
          r.mode  = MODE_NNUM;
        end
        ChP: begin
          r.pdots = '0;
          r.mode  = MODE_PNUM;
        end
        ChM: r.mode = MODE_MSEL;
        ChW: r.mode = MODE_WSEL;
        ChLess: begin
          if (st.octave > '0) r.octave = st.octave - OctW'(1);
        end
        ChMore: begin
          if (st.octave < OctW'(OctaveMax)) r.octave = st.octave + OctW'(1);
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic event_t make_event(input parse_state_t st, input logic endm);
    event_t e;
    e.kind  = st.pkind;
    e.note  = st.pnote;
    e.den   = st.pden;
    e.dots  = st.pdots;
    e.tempo = st.tempo;
    e.artic = st.artic;
    e.wave  = st.wave;
    e.full  = st.full;
    e.ssel  = st.ssel;
    e.endm  = endm;
    return e;
  endfunction

  function automatic logic is_number_mode(input mode_e m);
    return m == MODE_ONUM || m == MODE_LNUM || m == MODE_TNUM || m == MODE_NNUM ||
           m == MODE_PNUM || m == MODE_WNUM || m == MODE_NDIG;
  endfunction

  logic [ByteW-1:0] lc;
  logic             is_digit;
  logic [3:0]       digit;
  logic [ProdW-1:0] prod;
  logic [AccW-1:0]  acc_push;

  assign lc       = (text_byte_i >= ChUpA && text_byte_i <= ChUpZ) ?
                    (text_byte_i | 8'h20) : text_byte_i;
  assign is_digit = (text_byte_i >= ChZero) && (text_byte_i <= ChNine);
  assign digit    = text_byte_i[3:0];

  // acc * 10 + digit, saturating
  assign prod     = ProdW'({state_i.acc, 3'b000}) + ProdW'({state_i.acc, 1'b0})
                  + ProdW'(digit);
  assign acc_push = (prod > ProdW'(AccMax)) ? AccW'(AccMax) : prod[AccW-1:0];

  always_comb begin
    parse_state_t st;
    logic         done;
    st      = state_i;
    done    = 1'b0;
    emit_o  = 1'b0;
    event_o = make_event(state_i, 1'b0);

    if (end_of_text_i) begin
      if (is_number_mode(st.mode)) st = settle(st, sample_count_i);
      if (st.mode == MODE_NACC || st.mode == MODE_NLEN || st.mode == MODE_DOTS) begin
        emit_o  = 1'b1;
        event_o = make_event(st, 1'b1);
      end
      st.mode = MODE_IDLE;
    end else begin
      // number digits, or settle and fall through with the same byte
      if (is_number_mode(st.mode)) begin
        if (is_digit) begin
          st.acc = acc_push;
          done   = 1'b1;
        end else begin
          st = settle(st, sample_count_i);
        end
      end
      // accidental right after a note letter
      if (!done && st.mode == MODE_NACC) begin
        st.mode = MODE_NLEN;
        if (text_byte_i == ChMinus) begin
          st.pnote = st.pnote - NoteW'(1);
          done     = 1'b1;
        end else if (text_byte_i == ChPlus || text_byte_i == ChHash) begin
          st.pnote = st.pnote + NoteW'(1);
          done     = 1'b1;
        end
      end
      // optional length after a note
      if (!done && st.mode == MODE_NLEN) begin
        if (is_digit) begin
          st.acc  = AccW'(digit);
          st.mode = MODE_NDIG;
          done    = 1'b1;
        end else if (text_byte_i == ChDot) begin
          st.pdots = add_dot(st.pdots);
          st.mode  = MODE_DOTS;
          done     = 1'b1;
        end else begin
          emit_o  = 1'b1;
          event_o = make_event(st, 1'b0);
          st.mode = MODE_IDLE;
        end
      end
      // trailing dots, any other byte closes the event
      if (!done && st.mode == MODE_DOTS) begin
        if (text_byte_i == ChDot) begin
          st.pdots = add_dot(st.pdots);
          done     = 1'b1;
        end else begin
          emit_o  = 1'b1;
          event_o = make_event(st, 1'b0);
          st.mode = MODE_IDLE;
        end
      end
      if (!done) begin
        case (st.mode)
          MODE_COMMENT: begin
            if (text_byte_i == ChLf) st.mode = MODE_IDLE;
          end
          MODE_MSEL: begin
            st.mode = MODE_IDLE;
            case (lc)
              ChL:     st.artic = ArticLegato;
              ChN:     st.artic = ArticNormal;
              ChS:     st.artic = ArticStaccato;
              default: ;
            endcase
          end
          MODE_WSEL: begin
            st.mode = MODE_IDLE;
            if (is_digit) begin
              st.acc  = AccW'(digit);
              st.mode = MODE_WNUM;
            end else begin
              case (lc)
                ChS:     st.wave = WaveSine;
                ChQ:     st.wave = WaveSquare;
                ChW:     st.wave = WaveSawtooth;
                ChR:     st.wave = WaveRampDown;
                ChT:     st.wave = WaveTriangle;
                ChF:     st.full = 1'b1;
                ChN:     st.full = 1'b0;
                default: ;
              endcase
            end
          end
          default: st = do_command(st, text_byte_i, lc);
        endcase
      end
    end
    state_o = st;
  end

endmodule
